### hdl/table_index_code_decompressor_core_assert.svh
// Assertion macros used by the checker of this block.
`ifndef TABLE_INDEX_CODE_DECOMPRESSOR_CORE_ASSERT_SVH
`define TABLE_INDEX_CODE_DECOMPRESSOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define TIDC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TIDC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tidc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tidc_pkg
// Types, constants and helpers of the table-index code decompressor.
// ----------------------------------------------------------------------------
package tidc_pkg;

    localparam int TABLE_DEPTH     = 65536;
    localparam int MAX_INDEX_WIDTH = 16;
    localparam int TBL_AW          = $clog2(TABLE_DEPTH);

    localparam int WORD_W  = 32;
    localparam int PIX_W   = 24;
    localparam int ENT_W   = 16;
    localparam int BPE_W   = 3;
    localparam int FIELD_W = 16;
    localparam int CNT_W   = 5;
    localparam int CFG_W   = 24;

    localparam logic [ENT_W-1:0] LONG_ENTRIES = 16'h1000;
    localparam logic [CNT_W-1:0] FW_SHORT     = 5'd3;
    localparam logic [CNT_W-1:0] FW_LONG      = 5'd4;
    localparam logic [CNT_W-1:0] THR_SHORT    = 5'd6;
    localparam logic [CNT_W-1:0] THR_LONG     = 5'd14;
    localparam logic [CNT_W-1:0] REPEAT_BITS  = 5'd4;
    localparam logic [CNT_W-1:0] REPEAT_BIAS  = 5'd2;

    typedef enum logic [1:0] {
        CFG_BPE,
        CFG_ENTRIES,
        CFG_PIXELS
    } cfg_idx_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_CODE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_ZERO_WIDTH,
        ST_BAD_INDEX,
        ST_OVERFLOW
    } status_t;

    typedef enum logic [2:0] {
        PH_WIDTH,
        PH_REPEAT,
        PH_WIDTH2,
        PH_UNARY,
        PH_INDEX
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRECHK,
        S_BIT,
        S_EMIT,
        S_FINISH,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0] chunk_word;
        logic [PIX_W-1:0]  pixel_index;
        status_t           status;
        logic              last;
    } result_t;

    function automatic logic [WORD_W-1:0] mask_word(input logic [WORD_W-1:0] w,
                                                    input logic [BPE_W-1:0]  bpe);
        logic [WORD_W-1:0] r;
        unique case (bpe)
            3'd0:    r = '0;
            3'd1:    r = w & 32'h0000_00FF;
            3'd2:    r = w & 32'h0000_FFFF;
            3'd3:    r = w & 32'h00FF_FFFF;
            default: r = w;
        endcase
        return r;
    endfunction

endpackage

### hdl/tidc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tidc_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tidc_ram #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/table_index_code_decompressor_core.sv
// Table load: one transaction per cycle. Code byte time is set by the one-bit-per-cycle parser,
// which holds while a chunk is emitted or a result waits, and by the single table read port.
// A chunk shows on the result port after the next chunk is made or its byte is parsed.
// Reset (aresetn low, synchronous) clears parser, counters and valid flags, sets config defaults; table is not cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_index_code_decompressor_core
// Loads table words, then parses coded bytes into table indexes and emits
// one table word per pixel with its pixel index.
// ----------------------------------------------------------------------------
module table_index_code_decompressor_core
    import tidc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_idx,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_op,
    input  logic [15:0]       s_entry_index,
    input  logic [WORD_W-1:0] s_entry_word,
    input  logic [7:0]        s_code_byte,
    input  logic              s_stream_end,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [WORD_W-1:0] m_chunk_word,
    output logic [PIX_W-1:0]  m_pixel_index,
    output logic [1:0]        m_status,
    output logic              m_last
);

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [FIELD_W-1:0] field_bits_reg, field_bits_next;
    logic [CNT_W-1:0]   field_count_reg, field_count_next;
    logic [CNT_W-1:0]   repeat_reg, repeat_next;
    logic [CNT_W-1:0]   width_reg, width_next;
    logic [CNT_W-1:0]   rep_cnt_reg, rep_cnt_next;
    logic [PIX_W-1:0]   pixels_done_reg, pixels_done_next;
    logic               halted_reg, halted_next;
    logic [7:0]         code_reg, code_next;
    logic               end_reg, end_next;
    logic [2:0]         bit_reg, bit_next;
    logic               pend_valid_reg, pend_valid_next;
    result_t            pend_reg, pend_next;
    logic               m_valid_reg, m_valid_next;
    result_t            out_reg, out_next;
    logic [BPE_W-1:0]   bpe_reg;
    logic [ENT_W-1:0]   entries_reg;
    logic [PIX_W-1:0]   pixcnt_reg;

    logic               lng;
    logic [CNT_W-1:0]   fw, thr, fc_n, idx_need;
    logic               bit_in;
    logic [FIELD_W-1:0] fb_n;
    logic [31:0]        idx32;
    logic               idx_bad;
    phase_t             p_phase;
    logic [FIELD_W-1:0] p_field_bits;
    logic [CNT_W-1:0]   p_field_count, p_width, p_repeat;
    logic               p_fail, p_emit;
    status_t            p_status;

    logic               accept, out_free, push_ok, push, flush_go;
    logic               bit_stall, emit_last, emit_done, emit_go, start_fail, finish_end;
    result_t            push_data;
    logic               ram_we, ram_re;
    logic [WORD_W-1:0]  ram_rdata;

    tidc_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WORD_W)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (TBL_AW'(s_entry_index)),
        .wdata (s_entry_word),
        .re    (ram_re),
        .raddr (idx32[TBL_AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpe_reg     <= BPE_W'(4);
            entries_reg <= ENT_W'(1);
            pixcnt_reg  <= PIX_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_BPE:     bpe_reg     <= cfg_wdata[BPE_W-1:0];
                CFG_ENTRIES: entries_reg <= cfg_wdata[ENT_W-1:0];
                CFG_PIXELS:  pixcnt_reg  <= cfg_wdata[PIX_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin : parse
        lng      = entries_reg >= LONG_ENTRIES;
        fw       = lng ? FW_LONG : FW_SHORT;
        thr      = lng ? THR_LONG : THR_SHORT;
        bit_in   = code_reg[bit_reg];
        fb_n     = {field_bits_reg[FIELD_W-2:0], bit_in};
        fc_n     = field_count_reg + 5'd1;
        idx_need = (width_reg <= 5'd1) ? 5'd1 : width_reg - 5'd1;
        idx32    = (width_reg <= 5'd1) ? 32'(fb_n[0])
                                       : ((32'd1 << (width_reg - 5'd1)) | 32'(fb_n));
        idx_bad  = (idx32 >= 32'(entries_reg)) || (idx32 >= 32'(TABLE_DEPTH));
        p_phase       = phase_reg;
        p_field_bits  = field_bits_reg;
        p_field_count = field_count_reg;
        p_width       = width_reg;
        p_repeat      = repeat_reg;
        p_fail        = 1'b0;
        p_emit        = 1'b0;
        p_status      = ST_OK;
        unique case (phase_reg)
            PH_UNARY: begin
                if (bit_in) begin
                    if ({1'b0, width_reg} + 6'd1 > 6'(MAX_INDEX_WIDTH)) begin
                        p_fail   = 1'b1;
                        p_status = ST_OVERFLOW;
                    end else begin
                        p_width = width_reg + 5'd1;
                    end
                end else begin
                    p_phase = PH_INDEX;
                end
            end
            PH_WIDTH, PH_WIDTH2: begin
                if (fc_n < fw) begin
                    p_field_bits  = fb_n;
                    p_field_count = fc_n;
                end else begin
                    p_field_bits  = '0;
                    p_field_count = '0;
                    if (fb_n == '0) begin
                        if (phase_reg == PH_WIDTH) begin
                            p_phase = PH_REPEAT;
                        end else begin
                            p_fail   = 1'b1;
                            p_status = ST_ZERO_WIDTH;
                        end
                    end else begin
                        p_width = CNT_W'(fb_n);
                        if (32'(fb_n) > 32'(MAX_INDEX_WIDTH)) begin
                            p_fail   = 1'b1;
                            p_status = ST_OVERFLOW;
                        end else if (fb_n >= 16'd2 && CNT_W'(fb_n) - 5'd1 >= thr) begin
                            p_phase = PH_UNARY;
                        end else begin
                            p_phase = PH_INDEX;
                        end
                    end
                end
            end
            PH_REPEAT: begin
                if (fc_n < REPEAT_BITS) begin
                    p_field_bits  = fb_n;
                    p_field_count = fc_n;
                end else begin
                    p_repeat      = CNT_W'(fb_n[3:0]) + REPEAT_BIAS;
                    p_field_bits  = '0;
                    p_field_count = '0;
                    p_phase       = PH_WIDTH2;
                end
            end
            PH_INDEX: begin
                if (fc_n < idx_need) begin
                    p_field_bits  = fb_n;
                    p_field_count = fc_n;
                end else begin
                    p_field_bits  = '0;
                    p_field_count = '0;
                    if (idx_bad) begin
                        p_fail   = 1'b1;
                        p_status = ST_BAD_INDEX;
                    end else begin
                        p_emit = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign accept     = (state_reg == S_IDLE) && s_valid;
    assign out_free   = !m_valid_reg || m_ready;
    assign push_ok    = !pend_valid_reg || out_free;
    assign bit_stall  = p_fail && !push_ok;
    assign emit_last  = ({1'b0, pixels_done_reg} + 25'd1) >= {1'b0, pixcnt_reg};
    assign emit_done  = (rep_cnt_reg + 5'd1) >= repeat_reg;
    assign emit_go    = (state_reg == S_EMIT) && push_ok;
    assign start_fail = pixels_done_reg >= pixcnt_reg;
    assign finish_end = end_reg && !halted_reg;

    always_comb begin : next_state
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && s_op == OP_CODE && !halted_reg) begin
                    state_next = S_PRECHK;
                end
            end
            S_PRECHK: begin
                if (!start_fail) begin
                    state_next = S_BIT;
                end else if (push_ok) begin
                    state_next = S_FINISH;
                end
            end
            S_BIT: begin
                if (!bit_stall) begin
                    priority if (p_fail) begin
                        state_next = S_FINISH;
                    end else if (p_emit) begin
                        state_next = S_EMIT;
                    end else if (bit_reg == 3'd0) begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_EMIT: begin
                if (emit_go) begin
                    priority if (emit_last) begin
                        state_next = S_FINISH;
                    end else if (emit_done) begin
                        state_next = (bit_reg == 3'd0) ? S_FINISH : S_BIT;
                    end
                end
            end
            S_FINISH: state_next = S_FLUSH;
            S_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin : update
        phase_next       = phase_reg;
        field_bits_next  = field_bits_reg;
        field_count_next = field_count_reg;
        repeat_next      = repeat_reg;
        width_next       = width_reg;
        rep_cnt_next     = rep_cnt_reg;
        pixels_done_next = pixels_done_reg;
        halted_next      = halted_reg;
        code_next        = code_reg;
        end_next         = end_reg;
        bit_next         = bit_reg;
        pend_next        = pend_reg;
        push             = 1'b0;
        push_data        = '{chunk_word: '0, pixel_index: pixels_done_reg,
                             status: ST_OK, last: 1'b1};
        flush_go         = 1'b0;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && s_op == OP_LOAD) begin
                    ram_we = 32'(s_entry_index) < 32'(TABLE_DEPTH);
                end else if (accept && !halted_reg) begin
                    code_next = s_code_byte;
                    end_next  = s_stream_end;
                    bit_next  = 3'd7;
                end
            end
            S_PRECHK: begin
                if (start_fail && push_ok) begin
                    push        = 1'b1;
                    halted_next = 1'b1;
                end
            end
            S_BIT: begin
                if (!bit_stall) begin
                    phase_next       = p_phase;
                    field_bits_next  = p_field_bits;
                    field_count_next = p_field_count;
                    width_next       = p_width;
                    repeat_next      = p_repeat;
                    priority if (p_fail) begin
                        push             = 1'b1;
                        push_data.status = p_status;
                        halted_next      = 1'b1;
                    end else if (p_emit) begin
                        ram_re       = 1'b1;
                        rep_cnt_next = '0;
                    end else if (bit_reg != 3'd0) begin
                        bit_next = bit_reg - 3'd1;
                    end
                end
            end
            S_EMIT: begin
                if (emit_go) begin
                    push                 = 1'b1;
                    push_data.chunk_word = mask_word(ram_rdata, bpe_reg);
                    push_data.last       = emit_last;
                    pixels_done_next     = pixels_done_reg + PIX_W'(1);
                    rep_cnt_next         = rep_cnt_reg + 5'd1;
                    priority if (emit_last) begin
                        halted_next = 1'b1;
                    end else if (emit_done) begin
                        repeat_next = 5'd1;
                        phase_next  = PH_WIDTH;
                        if (bit_reg != 3'd0) begin
                            bit_next = bit_reg - 3'd1;
                        end
                    end
                end
            end
            S_FINISH: begin
                if (finish_end) begin
                    halted_next = 1'b1;
                    if (pend_valid_reg) begin
                        pend_next.last = 1'b1;
                    end else begin
                        push = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                flush_go = pend_valid_reg && out_free;
            end
            default: ;
        endcase
        if (push) begin
            pend_next = push_data;
        end
    end

    always_comb begin : out_path
        pend_valid_next = pend_valid_reg;
        m_valid_next    = m_valid_reg;
        out_next        = out_reg;
        if ((push && pend_valid_reg) || flush_go) begin
            out_next     = pend_reg;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (push) begin
            pend_valid_next = 1'b1;
        end else if (flush_go) begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_WIDTH;
            field_bits_reg  <= '0;
            field_count_reg <= '0;
            repeat_reg      <= 5'd1;
            width_reg       <= '0;
            rep_cnt_reg     <= '0;
            pixels_done_reg <= '0;
            halted_reg      <= 1'b0;
            bit_reg         <= '0;
            pend_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            field_bits_reg  <= field_bits_next;
            field_count_reg <= field_count_next;
            repeat_reg      <= repeat_next;
            width_reg       <= width_next;
            rep_cnt_reg     <= rep_cnt_next;
            pixels_done_reg <= pixels_done_next;
            halted_reg      <= halted_next;
            bit_reg         <= bit_next;
            pend_valid_reg  <= pend_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
        end_reg  <= end_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    always_comb begin : outputs
        s_ready       = (state_reg == S_IDLE);
        m_valid       = m_valid_reg;
        m_chunk_word  = out_reg.chunk_word;
        m_pixel_index = out_reg.pixel_index;
        m_status      = out_reg.status;
        m_last        = out_reg.last;
    end

endmodule

### hdl/tidc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tidc_checker
// Port-level checks of the decompressor result channel.
// ----------------------------------------------------------------------------
`include "table_index_code_decompressor_core_assert.svh"

module tidc_checker
    import tidc_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [WORD_W-1:0] m_chunk_word,
    input logic [PIX_W-1:0]  m_pixel_index,
    input logic [1:0]        m_status,
    input logic              m_last
);

    `TIDC_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_chunk_word) && $stable(m_pixel_index) && $stable(m_status) && $stable(m_last), "result changed while stalled")
    `TIDC_ASSERT_NXT(a_final, aclk, aresetn, m_valid && m_ready && m_last, !m_valid, "transaction after final result")
    `TIDC_ASSERT_NOW(a_err_last, aclk, aresetn, m_valid && m_status != ST_OK, m_last, "error result not final")
    `TIDC_ASSERT_NOW(a_err_zero, aclk, aresetn, m_valid && m_status != ST_OK, m_chunk_word == '0, "error result carries data")

endmodule

bind table_index_code_decompressor_core tidc_checker u_tidc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_chunk_word  (m_chunk_word),
    .m_pixel_index (m_pixel_index),
    .m_status      (m_status),
    .m_last        (m_last)
);
